// ===== src/lcd4_pkg.sv =====
package lcd4_pkg;

  // result list of one input item
  localparam int unsigned MAX_RES   = 6;
  localparam int unsigned RES_IDX_W = 3;

  // job queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // input item modes
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_LINE   = 3'd1;
  localparam logic [2:0] MODE_CHAR   = 3'd2;
  localparam logic [2:0] MODE_OFF    = 3'd3;
  localparam logic [2:0] MODE_SAMPLE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_TWO_LINES    = 3'd0;
  localparam logic [2:0] CFG_LARGE_FONT   = 3'd1;
  localparam logic [2:0] CFG_DISPLAY_ON   = 3'd2;
  localparam logic [2:0] CFG_CURSOR_ON    = 3'd3;
  localparam logic [2:0] CFG_CURSOR_BLINK = 3'd4;
  localparam logic [2:0] CFG_ADDR_INC     = 3'd5;
  localparam logic [2:0] CFG_DISP_SHIFT   = 3'd6;
  localparam logic [2:0] CFG_RETRY_LIMIT  = 3'd7;

  localparam logic [7:0] RETRY_RESET = 8'd25;

  // active sequence
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'd0,
    SEQ_INIT = 3'd1,
    SEQ_LINE = 3'd2,
    SEQ_CHAR = 3'd3,
    SEQ_OFF  = 3'd4
  } seq_t;

  // result kinds
  typedef enum logic [2:0] {
    K_NIB     = 3'd0,
    K_BUSY    = 3'd1,
    K_DONE    = 3'd2,
    K_TIMEOUT = 3'd3,
    K_LINEFIN = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       rs;
    logic [3:0] nib;
  } result_t;

  // one queued job: up to MAX_RES results, res[0] goes out first
  typedef struct packed {
    logic [RES_IDX_W-1:0]       cnt;
    result_t [MAX_RES-1:0]      res;
  } job_t;

  typedef struct packed {
    logic       two_lines;
    logic       large_font;
    logic       display_on;
    logic       cursor_on;
    logic       cursor_blink;
    logic       addr_inc;
    logic       disp_shift;
    logic [7:0] retry_limit;
  } cfg_t;

endpackage

// ===== src/char_lcd_4bit_sequencer.sv =====
// Channel  Handshake               Payload
// in       in_valid / in_ready     in_mode, in_line_select, in_char_code,
//                                  in_final_char, in_busy_req
// out      out_valid / out_ready   out_kind, out_reg_select, out_nibble, out_last
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An input item is taken every cycle while the four-entry job queue has room;
// the front end updates the sequencer state in the cycle of the transfer.
// The back end sends one result per cycle while out_ready is high; an item
// yields 1 to 6 results (initialise command 6, released chunk 3), and an
// ignored item yields none.
// The first result of an item passes through the queue storage and the output register; cfg_ready is always high.
// Reset (rst_n low at a clock edge) empties the queue and idles the sequencer.
module char_lcd_4bit_sequencer import lcd4_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic       in_line_select,
  input  logic [7:0] in_char_code,
  input  logic       in_final_char,
  input  logic       in_busy_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic       out_reg_select,
  output logic [3:0] out_nibble,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic push_valid;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t head_job;
  logic q_empty;

  lcd4_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_line_select (in_line_select),
    .in_char_code   (in_char_code),
    .in_final_char  (in_final_char),
    .in_busy_req    (in_busy_req),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push_valid     (push_valid),
    .push_job       (push_job),
    .q_full         (q_full)
  );

  lcd4_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .q_full     (q_full),
    .pop        (pop),
    .head_job   (head_job),
    .q_empty    (q_empty)
  );

  lcd4_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_empty        (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_reg_select (out_reg_select),
    .out_nibble     (out_nibble),
    .out_last       (out_last)
  );

endmodule

// ===== src/lcd4_front.sv =====
module lcd4_front import lcd4_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic       in_line_select,
  input  logic [7:0] in_char_code,
  input  logic       in_final_char,
  input  logic       in_busy_req,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  // job queue
  output logic       push_valid,
  output job_t       push_job,
  input  logic       q_full
);

  typedef result_t [1:0] pair_t;

  cfg_t       cfg_r;
  seq_t       seq_r, seq_nxt;
  logic [3:0] step_r, step_nxt;
  logic [7:0] fail_r, fail_nxt;
  logic       awaiting_r, awaiting_nxt;
  logic       held_line_r, held_line_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic       held_final_r, held_final_nxt;

  logic       accept;
  logic       is_cmd;
  logic       is_sample;
  logic [7:0] fail_inc;
  logic       timeout;
  logic [3:0] step_inc;
  logic [3:0] chunk_total;
  logic       finish;
  logic [3:0] fs_nib;
  pair_t      pair;

  function automatic result_t nib_res(input logic rs, input logic [3:0] n);
    result_t r;
    r.kind = K_NIB;
    r.rs   = rs;
    r.nib  = n;
    return r;
  endfunction

  function automatic result_t stat_res(input kind_t k);
    result_t r;
    r.kind = k;
    r.rs   = 1'b0;
    r.nib  = 4'h0;
    return r;
  endfunction

  // two nibbles of a chunk released by a not-busy sample
  function automatic pair_t chunk_pair(input seq_t seq, input logic [3:0] step,
                                       input cfg_t c, input logic hl,
                                       input logic [7:0] hc);
    pair_t p;
    unique case (seq)
      SEQ_INIT: begin
        p[0] = nib_res(1'b0, 4'h0);
        if (step == 4'd1) begin
          p[1] = nib_res(1'b0, {1'b1, c.display_on, c.cursor_on, c.cursor_blink});
        end else if (step == 4'd2) begin
          p[1] = nib_res(1'b0, 4'h1);
        end else begin
          p[1] = nib_res(1'b0, {2'b01, c.addr_inc, c.disp_shift});
        end
      end
      SEQ_LINE: begin
        if (step == 4'd0) begin
          p[0] = nib_res(1'b0, 4'h0);
          p[1] = nib_res(1'b0, 4'h1);
        end else if (step == 4'd1) begin
          p[0] = nib_res(1'b0, 4'h0);
          p[1] = nib_res(1'b0, 4'hC);
        end else begin
          p[0] = nib_res(1'b0, hl ? 4'hC : 4'h8);
          p[1] = nib_res(1'b0, 4'h0);
        end
      end
      SEQ_CHAR: begin
        p[0] = nib_res(1'b1, hc[7:4]);
        p[1] = nib_res(1'b1, hc[3:0]);
      end
      default: begin
        p[0] = nib_res(1'b0, 4'h0);
        p[1] = nib_res(1'b0, 4'h8);
      end
    endcase
    return p;
  endfunction

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_cmd    = (in_mode <= MODE_OFF);
  assign is_sample = (in_mode == MODE_SAMPLE) && awaiting_r && (seq_r != SEQ_IDLE);

  // busy retry bookkeeping
  assign fail_inc = (fail_r != 8'hFF) ? fail_r + 8'd1 : fail_r;
  assign timeout  = (fail_inc >= cfg_r.retry_limit);

  // chunk progress
  assign step_inc    = step_r + 4'd1;
  assign chunk_total = (seq_r == SEQ_INIT) ? 4'd4 : (seq_r == SEQ_LINE) ? 4'd3 : 4'd1;
  assign finish      = !(step_inc < chunk_total);
  assign fs_nib      = {cfg_r.two_lines, cfg_r.large_font, 2'b00};
  assign pair        = chunk_pair(seq_r, step_r, cfg_r, held_line_r, held_char_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.two_lines    <= 1'b1;
      cfg_r.large_font   <= 1'b0;
      cfg_r.display_on   <= 1'b1;
      cfg_r.cursor_on    <= 1'b0;
      cfg_r.cursor_blink <= 1'b0;
      cfg_r.addr_inc     <= 1'b1;
      cfg_r.disp_shift   <= 1'b0;
      cfg_r.retry_limit  <= RETRY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TWO_LINES:    cfg_r.two_lines    <= cfg_data[0];
        CFG_LARGE_FONT:   cfg_r.large_font   <= cfg_data[0];
        CFG_DISPLAY_ON:   cfg_r.display_on   <= cfg_data[0];
        CFG_CURSOR_ON:    cfg_r.cursor_on    <= cfg_data[0];
        CFG_CURSOR_BLINK: cfg_r.cursor_blink <= cfg_data[0];
        CFG_ADDR_INC:     cfg_r.addr_inc     <= cfg_data[0];
        CFG_DISP_SHIFT:   cfg_r.disp_shift   <= cfg_data[0];
        CFG_RETRY_LIMIT:  cfg_r.retry_limit  <= cfg_data;
        default:          cfg_r.retry_limit  <= cfg_data;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    seq_nxt        = seq_r;
    step_nxt       = step_r;
    fail_nxt       = fail_r;
    awaiting_nxt   = awaiting_r;
    held_line_nxt  = held_line_r;
    held_char_nxt  = held_char_r;
    held_final_nxt = held_final_r;
    if (accept) begin
      if (is_cmd) begin
        seq_nxt        = seq_t'(in_mode + 3'd1);
        fail_nxt       = 8'd0;
        held_line_nxt  = in_line_select;
        held_char_nxt  = in_char_code;
        held_final_nxt = in_final_char;
        step_nxt       = (in_mode == MODE_INIT) ? 4'd1 : 4'd0;
        awaiting_nxt   = 1'b1;
      end else if (is_sample) begin
        if (in_busy_req) begin
          fail_nxt = fail_inc;
          if (timeout) begin
            seq_nxt      = SEQ_IDLE;
            awaiting_nxt = 1'b0;
            step_nxt     = 4'd0;
          end
        end else if (finish) begin
          seq_nxt      = SEQ_IDLE;
          awaiting_nxt = 1'b0;
          step_nxt     = 4'd0;
        end else begin
          step_nxt = step_inc;
          if (seq_r == SEQ_INIT) begin
            fail_nxt = 8'd0;
          end
        end
      end
    end
  end

  // job for the back end
  always_comb begin
    push_job   = '0;
    push_valid = accept && (is_cmd || is_sample);
    if (is_cmd) begin
      if (in_mode == MODE_INIT) begin
        push_job.res[0] = nib_res(1'b0, 4'h3);
        push_job.res[1] = nib_res(1'b0, 4'h2);
        push_job.res[2] = nib_res(1'b0, fs_nib);
        push_job.res[3] = nib_res(1'b0, 4'h2);
        push_job.res[4] = nib_res(1'b0, fs_nib);
        push_job.res[5] = stat_res(K_BUSY);
        push_job.cnt    = 3'd6;
      end else begin
        push_job.res[0] = stat_res(K_BUSY);
        push_job.cnt    = 3'd1;
      end
    end else if (in_busy_req) begin
      push_job.res[0] = stat_res(timeout ? K_TIMEOUT : K_BUSY);
      push_job.cnt    = 3'd1;
    end else begin
      push_job.res[0] = pair[0];
      push_job.res[1] = pair[1];
      if (!finish) begin
        push_job.res[2] = stat_res(K_BUSY);
      end else if (seq_r == SEQ_CHAR && held_final_r) begin
        push_job.res[2] = stat_res(K_LINEFIN);
      end else begin
        push_job.res[2] = stat_res(K_DONE);
      end
      push_job.cnt = 3'd3;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= SEQ_IDLE;
      step_r       <= 4'd0;
      fail_r       <= 8'd0;
      awaiting_r   <= 1'b0;
      held_line_r  <= 1'b0;
      held_char_r  <= 8'd0;
      held_final_r <= 1'b0;
    end else begin
      seq_r        <= seq_nxt;
      step_r       <= step_nxt;
      fail_r       <= fail_nxt;
      awaiting_r   <= awaiting_nxt;
      held_line_r  <= held_line_nxt;
      held_char_r  <= held_char_nxt;
      held_final_r <= held_final_nxt;
    end
  end

  // idle sequencer carries no progress
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_IDLE) |-> (step_r == 4'd0 && !awaiting_r))
    else $error("idle sequencer with step or busy wait pending");

  // a command always leaves a fresh busy wait
  a_cmd_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_cmd) |=> (awaiting_r && fail_r == 8'd0 && seq_r != SEQ_IDLE))
    else $error("command did not open a busy wait");

  // a character finishes on its first released chunk
  a_char_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_sample && !in_busy_req && seq_r == SEQ_CHAR) |=> (seq_r == SEQ_IDLE))
    else $error("character sequence did not finish");

endmodule

// ===== src/lcd4_queue.sv =====
module lcd4_queue import lcd4_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic q_full,
  input  logic pop,
  output job_t head_job,
  output logic q_empty
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign q_full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_empty  = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_valid && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push_valid) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/lcd4_back.sv =====
module lcd4_back import lcd4_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // job queue head
  input  job_t       head_job,
  input  logic       q_empty,
  output logic       pop,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic       out_reg_select,
  output logic [3:0] out_nibble,
  output logic       out_last
);

  logic [RES_IDX_W-1:0] idx_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  logic                 out_last_r;
  logic                 load;
  logic                 is_last;
  result_t              cur;

  // output register free or being drained this cycle, and a job is queued
  assign load    = (!out_valid_r || out_ready) && !q_empty;
  assign cur     = head_job.res[idx_r];
  assign is_last = (idx_r == head_job.cnt - 3'd1);
  assign pop     = load && is_last;

  // walk the job's results one per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= cur;
      out_last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_res_r.kind;
  assign out_reg_select = out_res_r.rs;
  assign out_nibble     = out_res_r.nib;
  assign out_last       = out_last_r;

endmodule
